/* design/dqr_pkg.sv */
// shared types and codes for the array deque with reverse
`default_nettype none
package dqr_pkg;

   localparam int WORD_W   = 32;
   localparam int POS_W    = 4;
   localparam int STATUS_W = 2;
   localparam int FILL_W   = 5;
   localparam int CMD_W    = 3;

   typedef enum logic [CMD_W-1:0] {
      CMD_LIST       = 3'd0,
      CMD_PUSH_BACK  = 3'd1,
      CMD_PUSH_FRONT = 3'd2,
      CMD_POP_BACK   = 3'd3,
      CMD_POP_FRONT  = 3'd4,
      CMD_REVERSE    = 3'd5
   } cmd_type;

   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
   localparam logic [STATUS_W-1:0] ST_ITEM  = 2'd3;

   typedef struct packed {
      logic [WORD_W-1:0]   element;
      logic [POS_W-1:0]    position;
      logic                last;
      logic [STATUS_W-1:0] status;
      logic [FILL_W-1:0]   fill;
   } rsp_type;

endpackage
`default_nettype wire

/* design/dqr_mem.sv */
// element store: one write port, one registered read port
`default_nettype none
module dqr_mem
   import dqr_pkg::*;
#(
   parameter int DEPTH = 16,
   parameter int AW    = 4
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [AW-1:0]     wr_addr,
   input  wire logic [WORD_W-1:0] wr_data,
   input  wire logic              rd_en,
   input  wire logic [AW-1:0]     rd_addr,
   output logic      [WORD_W-1:0] rd_data
);

   logic [WORD_W-1:0] mem_ff [DEPTH];
   logic [WORD_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

/* design/dqr_ctrl.sv */
// command sequencer: walks the store one word at a time through the memory port
`default_nettype none
module dqr_ctrl
   import dqr_pkg::*;
#(
   parameter int DEPTH = 16,
   parameter int AW    = 4,
   parameter int CW    = 5
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic [CMD_W-1:0]  req_cmd,
   input  wire logic [WORD_W-1:0] req_value,
   input  wire logic              out_free,
   output logic                   emit_valid,
   output rsp_type                emit,
   output logic                   mem_wr_en,
   output logic      [AW-1:0]     mem_wr_addr,
   output logic      [WORD_W-1:0] mem_wr_data,
   output logic                   mem_rd_en,
   output logic      [AW-1:0]     mem_rd_addr,
   input  wire logic [WORD_W-1:0] mem_rd_data
);

   typedef enum logic [10:0] {
      S_IDLE   = 11'b000_0000_0001,
      S_LREAD  = 11'b000_0000_0010,
      S_LEMIT  = 11'b000_0000_0100,
      S_SREAD  = 11'b000_0000_1000,
      S_SWRITE = 11'b000_0001_0000,
      S_FRONTW = 11'b000_0010_0000,
      S_RRDI   = 11'b000_0100_0000,
      S_RRDJ   = 11'b000_1000_0000,
      S_RWRI   = 11'b001_0000_0000,
      S_RWRJ   = 11'b010_0000_0000,
      S_DONE   = 11'b100_0000_0000
   } state_type;

   localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

   state_type         state_ff, state_in;
   logic [CW-1:0]     fill_ff, fill_in;
   logic [CW-1:0]     idx_ff, idx_in;
   logic [AW-1:0]     hi_ff, hi_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic              front_ff, front_in;
   logic [WORD_W-1:0] val_ff, val_in;
   logic [WORD_W-1:0] tmp_ff, tmp_in;

   logic              accept;
   logic [CW-1:0]     idx_m1;
   logic [CW-1:0]     idx_p1;
   logic [CW:0]       idx_p2;
   logic [AW:0]       lo_p2;
   logic              full;
   logic              empty;

   function automatic logic [AW-1:0] idx_m1_fill(input logic [CW-1:0] f);
      logic [CW-1:0] d;
      d = f - 1'b1;
      return d[AW-1:0];
   endfunction

   assign accept = req_valid && (state_ff == S_IDLE);
   assign req_stall = (state_ff != S_IDLE);
   assign idx_m1 = idx_ff - 1'b1;
   assign idx_p1 = idx_ff + 1'b1;
   assign idx_p2 = {1'b0, idx_ff} + (CW+1)'(2);
   assign lo_p2 = {1'b0, idx_ff[AW-1:0]} + (AW+1)'(2);
   assign full = (fill_ff >= DEPTH_C);
   assign empty = (fill_ff == '0);

   always_comb begin
      state_in    = state_ff;
      fill_in     = fill_ff;
      idx_in      = idx_ff;
      hi_in       = hi_ff;
      status_in   = status_ff;
      front_in    = front_ff;
      val_in      = val_ff;
      tmp_in      = tmp_ff;
      mem_wr_en   = 1'b0;
      mem_wr_addr = idx_ff[AW-1:0];
      mem_wr_data = mem_rd_data;
      mem_rd_en   = 1'b0;
      mem_rd_addr = idx_ff[AW-1:0];
      emit_valid  = 1'b0;
      emit        = '0;
      emit.last   = 1'b1;
      emit.status = status_ff;
      emit.fill   = FILL_W'(fill_ff);

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               val_in    = req_value;
               status_in = ST_OK;
               idx_in    = '0;
               state_in  = S_DONE;
               case (cmd_type'(req_cmd))
                  CMD_LIST: begin
                     if (empty) begin
                        status_in = ST_EMPTY;
                     end else begin
                        state_in = S_LREAD;
                     end
                  end
                  CMD_PUSH_BACK: begin
                     if (full) begin
                        status_in = ST_FULL;
                     end else begin
                        mem_wr_en   = 1'b1;
                        mem_wr_addr = fill_ff[AW-1:0];
                        mem_wr_data = req_value;
                        fill_in     = fill_ff + 1'b1;
                     end
                  end
                  CMD_PUSH_FRONT: begin
                     front_in = 1'b1;
                     if (full) begin
                        status_in = ST_FULL;
                     end else if (empty) begin
                        state_in = S_FRONTW;
                     end else begin
                        idx_in   = fill_ff;
                        state_in = S_SREAD;
                     end
                  end
                  CMD_POP_BACK: begin
                     if (empty) begin
                        status_in = ST_EMPTY;
                     end else begin
                        fill_in = fill_ff - 1'b1;
                     end
                  end
                  CMD_POP_FRONT: begin
                     front_in = 1'b0;
                     if (empty) begin
                        status_in = ST_EMPTY;
                     end else if (fill_ff == CW'(1)) begin
                        fill_in = '0;
                     end else begin
                        state_in = S_SREAD;
                     end
                  end
                  CMD_REVERSE: begin
                     if (fill_ff >= CW'(2)) begin
                        hi_in    = idx_m1_fill(fill_ff);
                        state_in = S_RRDI;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_LREAD: begin
            mem_rd_en = 1'b1;
            state_in  = S_LEMIT;
         end
         S_LEMIT: begin
            emit.element  = mem_rd_data;
            emit.position = POS_W'(idx_ff);
            emit.last     = (idx_p1 == fill_ff);
            emit.status   = ST_ITEM;
            if (out_free) begin
               emit_valid = 1'b1;
               idx_in     = idx_p1;
               state_in   = emit.last ? S_IDLE : S_LREAD;
            end
         end
         S_SREAD: begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = front_ff ? idx_m1[AW-1:0] : idx_p1[AW-1:0];
            state_in    = S_SWRITE;
         end
         S_SWRITE: begin
            mem_wr_en = 1'b1;
            if (front_ff) begin
               idx_in   = idx_m1;
               state_in = (idx_m1 == '0) ? S_FRONTW : S_SREAD;
            end else begin
               idx_in = idx_p1;
               if (idx_p2 < {1'b0, fill_ff}) begin
                  state_in = S_SREAD;
               end else begin
                  fill_in  = fill_ff - 1'b1;
                  state_in = S_DONE;
               end
            end
         end
         S_FRONTW: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = '0;
            mem_wr_data = val_ff;
            fill_in     = fill_ff + 1'b1;
            state_in    = S_DONE;
         end
         S_RRDI: begin
            mem_rd_en = 1'b1;
            state_in  = S_RRDJ;
         end
         S_RRDJ: begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = hi_ff;
            tmp_in      = mem_rd_data;
            state_in    = S_RWRI;
         end
         S_RWRI: begin
            mem_wr_en = 1'b1;
            state_in  = S_RWRJ;
         end
         S_RWRJ: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = hi_ff;
            mem_wr_data = tmp_ff;
            idx_in      = idx_p1;
            hi_in       = hi_ff - 1'b1;
            state_in    = (lo_p2 < {1'b0, hi_ff}) ? S_RRDI : S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               emit_valid = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         fill_ff  <= '0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff    <= idx_in;
      hi_ff     <= hi_in;
      status_ff <= status_in;
      front_ff  <= front_in;
      val_ff    <= val_in;
      tmp_ff    <= tmp_in;
   end

endmodule
`default_nettype wire

/* design/array_deque_with_reverse.sv */
// top level of the array deque with reverse: sequencer, store and result register
//
// channel  ports                                         direction
// req      req_valid req_stall req_cmd req_value         in
// rsp      rsp_valid rsp_stall rsp_element rsp_position  out
//          rsp_last rsp_status rsp_fill
//
// one command at a time; req_stall is high until its last word is sent
// push back, pop back, other codes, empty cases go to the done state; list reads
// and sends one element at a time; push and pop front shift each element by a read
// and a write; reverse swaps pairs by two reads and two writes
// reset empties the store (fill 0); contents are left as they were
// rsp_stall holds the result register; the sequencer waits behind it
`default_nettype none
module array_deque_with_reverse
   import dqr_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire logic        [CMD_W-1:0]  req_cmd,
   input  wire logic signed [WORD_W-1:0] req_value,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output logic signed      [WORD_W-1:0] rsp_element,
   output logic             [POS_W-1:0]  rsp_position,
   output logic                          rsp_last,
   output logic             [STATUS_W-1:0] rsp_status,
   output logic             [FILL_W-1:0] rsp_fill
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   logic              out_free;
   logic              emit_valid;
   rsp_type           emit;
   logic              mem_wr_en;
   logic [AW-1:0]     mem_wr_addr;
   logic [WORD_W-1:0] mem_wr_data;
   logic              mem_rd_en;
   logic [AW-1:0]     mem_rd_addr;
   logic [WORD_W-1:0] mem_rd_data;

   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_word_ff, rsp_word_in;

   dqr_ctrl #(
      .DEPTH(DEPTH),
      .AW   (AW),
      .CW   (CW)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_cmd    (req_cmd),
      .req_value  (req_value),
      .out_free   (out_free),
      .emit_valid (emit_valid),
      .emit       (emit),
      .mem_wr_en  (mem_wr_en),
      .mem_wr_addr(mem_wr_addr),
      .mem_wr_data(mem_wr_data),
      .mem_rd_en  (mem_rd_en),
      .mem_rd_addr(mem_rd_addr),
      .mem_rd_data(mem_rd_data)
   );

   dqr_mem #(
      .DEPTH(DEPTH),
      .AW   (AW)
   ) u_mem (
      .clock  (clock),
      .wr_en  (mem_wr_en),
      .wr_addr(mem_wr_addr),
      .wr_data(mem_wr_data),
      .rd_en  (mem_rd_en),
      .rd_addr(mem_rd_addr),
      .rd_data(mem_rd_data)
   );

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_word_in  = rsp_word_ff;
      if (emit_valid) begin
         rsp_valid_in = 1'b1;
         rsp_word_in  = emit;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_element  = rsp_word_ff.element;
   assign rsp_position = rsp_word_ff.position;
   assign rsp_last     = rsp_word_ff.last;
   assign rsp_status   = rsp_word_ff.status;
   assign rsp_fill     = rsp_word_ff.fill;

endmodule
`default_nettype wire

/* verif/tb_array_deque_with_reverse.sv */
// testbench for the array deque with reverse: random and directed commands checked word by word
module tb_array_deque_with_reverse;
   import dqr_pkg::*;

   localparam int DEPTH = 16;
   localparam logic [CMD_W-1:0] CMD_RSVD_LO = 3'd6;
   localparam logic [CMD_W-1:0] CMD_RSVD_HI = 3'd7;
   localparam int RANDOM_ITEMS = 270;
   localparam int TAIL_CYCLES = 60;

   typedef struct {
      logic [CMD_W-1:0]         op;
      logic signed [WORD_W-1:0] value;
   } deque_cmd_type;

   logic                        clock;
   logic                        reset;
   logic                        req_valid;
   logic                        req_stall;
   logic        [CMD_W-1:0]     req_cmd;
   logic signed [WORD_W-1:0]    req_value;
   logic                        rsp_valid;
   logic                        rsp_stall;
   logic signed [WORD_W-1:0]    rsp_element;
   logic        [POS_W-1:0]     rsp_position;
   logic                        rsp_last;
   logic        [STATUS_W-1:0]  rsp_status;
   logic        [FILL_W-1:0]    rsp_fill;

   // predicted contents of the deque
   logic signed [WORD_W-1:0] deque_mem [DEPTH];
   int unsigned              deque_fill;

   deque_cmd_type cmd_q [$];
   rsp_type    words_due [$];

   bit drv_busy;
   bit req_taken;
   bit rsp_taken;
   int drv_gap;
   int rcv_wait;
   int rcv_hold;
   int snd_calm;
   int rcv_calm;
   int n_queued;
   int n_accepted;
   int n_errors;

   array_deque_with_reverse #(.DEPTH(DEPTH)) i_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_cmd      (req_cmd),
      .req_value    (req_value),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_element  (rsp_element),
      .rsp_position (rsp_position),
      .rsp_last     (rsp_last),
      .rsp_status   (rsp_status),
      .rsp_fill     (rsp_fill)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #1_200_000;
      $display("== FAIL ==");
      $finish;
   end

   function automatic int draw_wait(inout int calm);
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 15) == 0) begin
         calm = $urandom_range(10, 40);
         return 0;
      end
      return $urandom_range(0, 19);
   endfunction

   function automatic logic signed [WORD_W-1:0] pick_value();
      case ($urandom_range(0, 11))
         0: return 32'sh7FFF_FFFF;
         1: return 32'sh8000_0000;
         2: return 32'sh0000_0000;
         3: return -32'sd1;
         default: return $urandom;
      endcase
   endfunction

   task automatic predict_words(input logic [CMD_W-1:0] op, input logic signed [WORD_W-1:0] val);
      rsp_type                  w;
      logic [STATUS_W-1:0]      st;
      logic signed [WORD_W-1:0] t;
      st = ST_OK;
      w.element = '0;
      w.position = '0;
      w.last = 1'b1;
      if (op == CMD_LIST) begin
         if (deque_fill == 0) begin
            w.status = ST_EMPTY;
            w.fill = '0;
            words_due.push_back(w);
         end else begin
            for (int i = 0; i < deque_fill; i++) begin
               w.element = deque_mem[i];
               w.position = POS_W'(i);
               w.last = (i == deque_fill - 1);
               w.status = ST_ITEM;
               w.fill = FILL_W'(deque_fill);
               words_due.push_back(w);
            end
         end
         return;
      end
      case (op)
         CMD_PUSH_BACK: begin
            if (deque_fill >= DEPTH) st = ST_FULL;
            else begin
               deque_mem[deque_fill] = val;
               deque_fill++;
            end
         end
         CMD_PUSH_FRONT: begin
            if (deque_fill >= DEPTH) st = ST_FULL;
            else begin
               for (int i = deque_fill; i > 0; i--) deque_mem[i] = deque_mem[i-1];
               deque_mem[0] = val;
               deque_fill++;
            end
         end
         CMD_POP_BACK: begin
            if (deque_fill == 0) st = ST_EMPTY;
            else deque_fill--;
         end
         CMD_POP_FRONT: begin
            if (deque_fill == 0) st = ST_EMPTY;
            else begin
               for (int i = 0; i + 1 < deque_fill; i++) deque_mem[i] = deque_mem[i+1];
               deque_fill--;
            end
         end
         CMD_REVERSE: begin
            for (int i = 0; i < deque_fill / 2; i++) begin
               t = deque_mem[i];
               deque_mem[i] = deque_mem[deque_fill-1-i];
               deque_mem[deque_fill-1-i] = t;
            end
         end
         default: ;
      endcase
      w.status = st;
      w.fill = FILL_W'(deque_fill);
      words_due.push_back(w);
   endtask

   task automatic check_field(input string what, input logic signed [63:0] want_v,
                              input logic signed [63:0] got_v);
      if (got_v !== want_v) begin
         $display("%0t: %s expected %0d got %0d", $time, what, want_v, got_v);
         n_errors++;
      end
   endtask

   // sample both channels at the rising edge
   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            rsp_taken = 1'b1;
            if (words_due.size() == 0) begin
               $display("%0t: unexpected word expected none got element %0d status %0d",
                        $time, rsp_element, rsp_status);
               n_errors++;
            end else begin
               want = words_due.pop_front();
               check_field("element", $signed(want.element), rsp_element);
               check_field("position", want.position, rsp_position);
               check_field("last", want.last, rsp_last);
               check_field("status", want.status, rsp_status);
               check_field("fill", want.fill, rsp_fill);
            end
         end
         if (req_valid && !req_stall) begin
            req_taken = 1'b1;
            n_accepted++;
            predict_words(req_cmd, req_value);
         end
      end
   end

   // sender
   always @(negedge clock) begin
      deque_cmd_type cur;
      if (!reset) begin
         if (req_taken) begin
            req_taken = 1'b0;
            drv_busy = 1'b0;
            drv_gap = draw_wait(snd_calm);
         end
         if (!drv_busy) begin
            if (drv_gap > 0) drv_gap--;
            else if (cmd_q.size() != 0) begin
               cur = cmd_q.pop_front();
               req_cmd <= cur.op;
               req_value <= cur.value;
               drv_busy = 1'b1;
            end
         end
         req_valid <= drv_busy;
      end
   end

   // receiver
   always @(negedge clock) begin
      if (!reset) begin
         if (rsp_taken) begin
            rsp_taken = 1'b0;
            rcv_wait = draw_wait(rcv_calm);
         end
         if (rcv_hold > 0) begin
            rcv_hold--;
            rsp_stall <= 1'b1;
         end else if (rcv_wait > 0) begin
            rcv_wait--;
            rsp_stall <= 1'b1;
         end else rsp_stall <= 1'b0;
      end
   end

   task automatic queue_cmd(input logic [CMD_W-1:0] op, input logic signed [WORD_W-1:0] val);
      deque_cmd_type c;
      c.op = op;
      c.value = val;
      cmd_q.push_back(c);
      n_queued++;
   endtask

   task automatic add_fill_run(input int n);
      for (int i = 0; i < n; i++)
         queue_cmd($urandom_range(0, 1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT, pick_value());
      queue_cmd(CMD_LIST, pick_value());
   endtask

   task automatic add_drain_run(input int n);
      for (int i = 0; i < n; i++)
         queue_cmd($urandom_range(0, 1) ? CMD_POP_BACK : CMD_POP_FRONT, pick_value());
      queue_cmd(CMD_LIST, pick_value());
   endtask

   task automatic wait_drained();
      while (n_accepted < n_queued || words_due.size() != 0) @(negedge clock);
   endtask

   initial begin
      int  start;
      bit  mid_done;
      int  n;
      reset = 1'b1;
      req_valid = 1'b0;
      req_cmd = '0;
      req_value = '0;
      rsp_stall = 1'b0;
      drv_busy = 1'b0;
      req_taken = 1'b0;
      rsp_taken = 1'b0;
      drv_gap = 0;
      rcv_wait = 0;
      rcv_hold = 0;
      snd_calm = 0;
      rcv_calm = 0;
      n_queued = 0;
      n_accepted = 0;
      n_errors = 0;
      deque_fill = 0;
      mid_done = 1'b0;
      foreach (deque_mem[i]) deque_mem[i] = '0;

      // empty store cases, single element, extremes, odd and even reverse
      queue_cmd(CMD_LIST, 0);
      queue_cmd(CMD_POP_BACK, 0);
      queue_cmd(CMD_POP_FRONT, 0);
      queue_cmd(CMD_REVERSE, 0);
      queue_cmd(CMD_RSVD_LO, -32'sd1);
      queue_cmd(CMD_PUSH_BACK, 32'sh7FFF_FFFF);
      queue_cmd(CMD_REVERSE, 0);
      queue_cmd(CMD_LIST, 0);
      queue_cmd(CMD_PUSH_FRONT, 32'sh8000_0000);
      queue_cmd(CMD_PUSH_BACK, -32'sd1);
      queue_cmd(CMD_PUSH_FRONT, 0);
      queue_cmd(CMD_LIST, 0);
      queue_cmd(CMD_REVERSE, 0);
      queue_cmd(CMD_LIST, 0);
      queue_cmd(CMD_POP_FRONT, 0);
      queue_cmd(CMD_REVERSE, 0);
      queue_cmd(CMD_LIST, 0);
      queue_cmd(CMD_POP_BACK, 0);
      queue_cmd(CMD_RSVD_HI, 32'sh5A5A_A5A5);
      queue_cmd(CMD_POP_BACK, 0);
      queue_cmd(CMD_POP_FRONT, 0);
      queue_cmd(CMD_LIST, 0);

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      wait_drained();
      @(posedge clock);
      // long receiver hold so the block backs up while commands keep coming
      rcv_hold = 300;
      start = n_queued;
      add_fill_run(DEPTH + 3);
      queue_cmd(CMD_REVERSE, 0);
      queue_cmd(CMD_LIST, 0);
      while (n_queued - start < RANDOM_ITEMS) begin
         if (!mid_done && n_queued - start >= RANDOM_ITEMS / 2) begin
            while (cmd_q.size() != 0) @(negedge clock);
            @(posedge clock);
            rcv_hold = 250;
            mid_done = 1'b1;
         end
         case ($urandom_range(0, 9))
            0, 1, 2: add_fill_run($urandom_range(DEPTH / 2, DEPTH + 4));
            3, 4: add_drain_run($urandom_range(DEPTH / 2, DEPTH + 3));
            5, 6, 7: begin
               n = $urandom_range(6, 12);
               for (int i = 0; i < n; i++)
                  queue_cmd(CMD_W'($urandom_range(CMD_LIST, CMD_REVERSE)), pick_value());
            end
            8: begin
               queue_cmd(CMD_REVERSE, pick_value());
               queue_cmd(CMD_LIST, pick_value());
            end
            default: begin
               n = $urandom_range(2, 5);
               for (int i = 0; i < n; i++)
                  queue_cmd(CMD_W'($urandom_range(CMD_LIST, CMD_RSVD_HI)), $urandom);
            end
         endcase
      end

      wait_drained();
      repeat (TAIL_CYCLES) @(negedge clock);
      if (n_errors == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end

endmodule
